// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPL(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);

// a implies b in the next cycle
`define ASSERT_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);

`endif

// ----- src/tstc_pkg.sv -----
// shared types and constants of the timestamp tolerance clustering block
// no dependencies
package tstc_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [31:0] TOL_RESET = 32'd500;

	typedef struct packed {
		logic [31:0] time_ms;
		logic        last;
	} in_t;

	typedef struct packed {
		logic [6:0] num_variants;
		logic       has_conflict;
		logic       overflow;
	} out_t;

	typedef enum logic [4:0] {
		BS_IDLE,
		BS_DUP_RD,
		BS_DUP_CMP,
		BS_SEL_START,
		BS_SEL_RD,
		BS_SEL_CMP,
		BS_CL_RD,
		BS_CL_CMP,
		BS_CL_MUL1,
		BS_CL_MUL2,
		BS_CL_DSTART,
		BS_CL_DIV,
		BS_DS_RD_I,
		BS_DS_HOLD,
		BS_DS_RD_K,
		BS_DS_CMP,
		BS_OUT
	} back_state_t;

endpackage

// ----- src/timestamp_tolerance_clustering_top.sv -----
// top level of the timestamp tolerance clustering block
// depends on tstc_pkg, tstc_front, tstc_back and assert_macros.svh
//
// channel   handshake              payload
// in        in_valid / in_ready    in_data   (tstc_pkg::in_t)
// out       out_valid / out_ready  out_data  (tstc_pkg::out_t)
// cfg       cfg_we                 cfg_wdata (tolerance)
//
// a request is compared with each group held so far, one stored value at a time through the
// single read port of the value store; a four deep queue takes requests meanwhile
// closing orders the groups by value, compares each with the clusters in turn and either
// merges it into the first within tolerance (two multiply steps, then the serial divider)
// or opens a new cluster while room is left, and then counts the distinct centroids
// reset clears counters, control and the held result only, stores are never cleared; a result
// held in the output register does not stop the queue from filling
`include "assert_macros.svh"
module timestamp_tolerance_clustering_top #(
	parameter int MAX_ITEMS = tstc_pkg::MAX_ITEMS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tstc_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tstc_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata
);

	logic [31:0]   tol_q;
	logic          q_valid, q_ready;
	tstc_pkg::in_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= tstc_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	tstc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	tstc_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.tol(tol_q), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	`ASSERT_IMPL(a_conflict, out_valid, out_data.has_conflict == (out_data.num_variants > 7'd1), "conflict flag mismatch")
	`ASSERT_IMPL(a_full_queue, !in_ready, q_valid, "full queue seen as empty")
	`ASSERT_NEXT(a_cfg_write, cfg_we, tol_q == $past(cfg_wdata), "tolerance not written")

endmodule

// ----- src/tstc_front.sv -----
// front end: accepts requests and queues them for the back end
// depends on tstc_pkg
module tstc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tstc_pkg::in_t in_data,
	output logic          q_valid,
	input  logic          q_ready,
	output tstc_pkg::in_t q_data
);

	localparam int PW = $clog2(tstc_pkg::QUEUE_DEPTH);

	tstc_pkg::in_t mem_q [tstc_pkg::QUEUE_DEPTH];
	logic [PW:0] wr_q, rd_q;
	logic push, pop;

	assign in_ready = (wr_q[PW-1:0] != rd_q[PW-1:0]) || (wr_q[PW] == rd_q[PW]);
	assign q_valid  = (wr_q != rd_q);
	assign q_data   = mem_q[rd_q[PW-1:0]];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q[PW-1:0]] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

endmodule

// ----- src/tstc_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on nothing
module tstc_div #(
	parameter int NW = 39,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CNW = $clog2(NW + 1);

	logic [DW-1:0]  rem_q;
	logic [NW-1:0]  quo_q;
	logic [DW-1:0]  den_q;
	logic [CNW-1:0] cnt_q;
	logic           done_q;
	logic [DW:0]    trial;
	logic           fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNW'(1));
			if (start) begin
				cnt_q <= CNW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/tstc_back.sv -----
// back end: grouping, ordered clustering and distinct centroid count
// depends on tstc_pkg and tstc_div
module tstc_back #(
	parameter int MAX_ITEMS = tstc_pkg::MAX_ITEMS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  tstc_pkg::in_t  q_data,
	input  logic [31:0]    tol,
	output logic           out_valid,
	input  logic           out_ready,
	output tstc_pkg::out_t out_data
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int SW = 32 + CW;

	tstc_pkg::back_state_t st_q, st_d;

	logic [31:0]   vmem [MAX_ITEMS];
	logic [CW-1:0] wmem [MAX_ITEMS];
	logic [31:0]   cmem [MAX_ITEMS];
	logic [CW-1:0] cwmem [MAX_ITEMS];
	logic [31:0]   vrd_q, crd_q;
	logic [CW-1:0] wrd_q, cwrd_q;

	logic [CW-1:0] gcnt_q, icnt_q, nc_q, idx_q, k_q, i_q, dist_q, tw_q, bestw_q;
	logic          ovf_q, last_q, found_q, have_prev_q;
	logic [31:0]   t_q, best_q, prev_q, c_q;
	logic [CW-1:0] cw_q;
	logic [SW-1:0] p_q, sum_q;
	logic          res_v_q;
	tstc_pkg::out_t res_q;

	logic          v_we, c_we;
	logic [AW-1:0] v_waddr, c_waddr, caddr;
	logic [31:0]   v_wdata, c_wdata;
	logic [CW-1:0] w_wdata, cw_wdata;
	logic [31:0]   dist_abs;
	logic          div_start, div_done;
	logic [SW-1:0] div_quo;
	logic          take;

	assign dist_abs  = (best_q >= crd_q) ? best_q - crd_q : crd_q - best_q;
	assign take      = q_valid && (st_q == tstc_pkg::BS_IDLE);
	assign q_ready   = (st_q == tstc_pkg::BS_IDLE);
	assign out_valid = res_v_q;
	assign out_data  = res_q;
	assign div_start = (st_q == tstc_pkg::BS_CL_DSTART);

	tstc_div #(.NW(SW), .DW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(sum_q), .den(tw_q),
		.done(div_done), .quo(div_quo)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			tstc_pkg::BS_IDLE: begin
				if (q_valid) begin
					if (icnt_q < CW'(MAX_ITEMS)) st_d = tstc_pkg::BS_DUP_RD;
					else st_d = q_data.last ? tstc_pkg::BS_SEL_START : tstc_pkg::BS_IDLE;
				end
			end
			tstc_pkg::BS_DUP_RD: begin
				if (idx_q == gcnt_q) st_d = last_q ? tstc_pkg::BS_SEL_START : tstc_pkg::BS_IDLE;
				else st_d = tstc_pkg::BS_DUP_CMP;
			end
			tstc_pkg::BS_DUP_CMP: begin
				if (vrd_q == t_q) st_d = last_q ? tstc_pkg::BS_SEL_START : tstc_pkg::BS_IDLE;
				else st_d = tstc_pkg::BS_DUP_RD;
			end
			tstc_pkg::BS_SEL_START: st_d = tstc_pkg::BS_SEL_RD;
			tstc_pkg::BS_SEL_RD: begin
				if (idx_q != gcnt_q) st_d = tstc_pkg::BS_SEL_CMP;
				else st_d = found_q ? tstc_pkg::BS_CL_RD : tstc_pkg::BS_DS_RD_I;
			end
			tstc_pkg::BS_SEL_CMP: st_d = tstc_pkg::BS_SEL_RD;
			tstc_pkg::BS_CL_RD: st_d = (k_q == nc_q) ? tstc_pkg::BS_SEL_START : tstc_pkg::BS_CL_CMP;
			tstc_pkg::BS_CL_CMP: st_d = (dist_abs <= tol) ? tstc_pkg::BS_CL_MUL1 : tstc_pkg::BS_CL_RD;
			tstc_pkg::BS_CL_MUL1: st_d = tstc_pkg::BS_CL_MUL2;
			tstc_pkg::BS_CL_MUL2: st_d = tstc_pkg::BS_CL_DSTART;
			tstc_pkg::BS_CL_DSTART: st_d = tstc_pkg::BS_CL_DIV;
			tstc_pkg::BS_CL_DIV: if (div_done) st_d = tstc_pkg::BS_SEL_START;
			tstc_pkg::BS_DS_RD_I: st_d = (i_q == nc_q) ? tstc_pkg::BS_OUT : tstc_pkg::BS_DS_HOLD;
			tstc_pkg::BS_DS_HOLD: st_d = tstc_pkg::BS_DS_RD_K;
			tstc_pkg::BS_DS_RD_K: st_d = (k_q == i_q) ? tstc_pkg::BS_DS_RD_I : tstc_pkg::BS_DS_CMP;
			tstc_pkg::BS_DS_CMP: st_d = (crd_q == c_q) ? tstc_pkg::BS_DS_RD_I : tstc_pkg::BS_DS_RD_K;
			tstc_pkg::BS_OUT: if (!res_v_q || out_ready) st_d = tstc_pkg::BS_IDLE;
			default: st_d = tstc_pkg::BS_IDLE;
		endcase
	end

	always_comb begin
		v_we     = 1'b0;
		v_waddr  = gcnt_q[AW-1:0];
		v_wdata  = t_q;
		w_wdata  = CW'(1);
		c_we     = 1'b0;
		c_waddr  = nc_q[AW-1:0];
		c_wdata  = best_q;
		cw_wdata = bestw_q;
		caddr    = (st_q == tstc_pkg::BS_DS_RD_I) ? i_q[AW-1:0] : k_q[AW-1:0];
		case (st_q)
			tstc_pkg::BS_DUP_RD: v_we = (idx_q == gcnt_q);
			tstc_pkg::BS_DUP_CMP: begin
				v_we    = (vrd_q == t_q);
				v_waddr = idx_q[AW-1:0];
				v_wdata = vrd_q;
				w_wdata = wrd_q + 1'b1;
			end
			tstc_pkg::BS_CL_RD: c_we = (k_q == nc_q) && (nc_q < CW'(MAX_ITEMS));
			tstc_pkg::BS_CL_DIV: begin
				c_we     = div_done;
				c_waddr  = k_q[AW-1:0];
				c_wdata  = div_quo[31:0];
				cw_wdata = tw_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			vmem[v_waddr] <= v_wdata;
			wmem[v_waddr] <= w_wdata;
		end
		if (c_we) begin
			cmem[c_waddr]  <= c_wdata;
			cwmem[c_waddr] <= cw_wdata;
		end
		vrd_q  <= vmem[idx_q[AW-1:0]];
		wrd_q  <= wmem[idx_q[AW-1:0]];
		crd_q  <= cmem[caddr];
		cwrd_q <= cwmem[caddr];
	end

	always_ff @(posedge clk) begin
		case (st_q)
			tstc_pkg::BS_IDLE: begin
				t_q    <= q_data.time_ms;
				last_q <= q_data.last;
				idx_q  <= '0;
			end
			tstc_pkg::BS_DUP_CMP: idx_q <= idx_q + 1'b1;
			tstc_pkg::BS_SEL_START: idx_q <= '0;
			tstc_pkg::BS_SEL_RD: begin
				k_q <= '0;
				i_q <= '0;
				dist_q <= '0;
			end
			tstc_pkg::BS_SEL_CMP: begin
				if ((!have_prev_q || vrd_q > prev_q) && (!found_q || vrd_q < best_q)) begin
					best_q  <= vrd_q;
					bestw_q <= wrd_q;
				end
				idx_q <= idx_q + 1'b1;
			end
			tstc_pkg::BS_CL_CMP: begin
				c_q  <= crd_q;
				cw_q <= cwrd_q;
				tw_q <= cwrd_q + bestw_q;
				if (dist_abs > tol) k_q <= k_q + 1'b1;
			end
			tstc_pkg::BS_CL_MUL1: p_q <= SW'(c_q) * SW'(cw_q);
			tstc_pkg::BS_CL_MUL2: sum_q <= p_q + SW'(best_q) * SW'(bestw_q);
			tstc_pkg::BS_DS_RD_I: k_q <= '0;
			tstc_pkg::BS_DS_HOLD: c_q <= crd_q;
			tstc_pkg::BS_DS_RD_K: begin
				if (k_q == i_q) begin
					dist_q <= dist_q + 1'b1;
					i_q    <= i_q + 1'b1;
				end
			end
			tstc_pkg::BS_DS_CMP: begin
				if (crd_q == c_q) i_q <= i_q + 1'b1;
				else k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tstc_pkg::BS_IDLE;
			gcnt_q      <= '0;
			icnt_q      <= '0;
			nc_q        <= '0;
			ovf_q       <= 1'b0;
			found_q     <= 1'b0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			res_v_q     <= 1'b0;
			res_q       <= '0;
		end else begin
			st_q <= st_d;
			if (res_v_q && out_ready && st_q != tstc_pkg::BS_OUT) res_v_q <= 1'b0;
			case (st_q)
				tstc_pkg::BS_IDLE: begin
					if (take && icnt_q >= CW'(MAX_ITEMS)) ovf_q <= 1'b1;
				end
				tstc_pkg::BS_DUP_RD: begin
					if (idx_q == gcnt_q) begin
						gcnt_q <= gcnt_q + 1'b1;
						icnt_q <= icnt_q + 1'b1;
					end
				end
				tstc_pkg::BS_DUP_CMP: begin
					if (vrd_q == t_q) icnt_q <= icnt_q + 1'b1;
				end
				tstc_pkg::BS_SEL_START: found_q <= 1'b0;
				tstc_pkg::BS_SEL_RD: begin
					if (idx_q == gcnt_q && found_q) begin
						have_prev_q <= 1'b1;
						prev_q      <= best_q;
					end
				end
				tstc_pkg::BS_SEL_CMP: begin
					if ((!have_prev_q || vrd_q > prev_q) && (!found_q || vrd_q < best_q)) begin
						found_q <= 1'b1;
					end
				end
				tstc_pkg::BS_CL_RD: begin
					if (k_q == nc_q && nc_q < CW'(MAX_ITEMS)) nc_q <= nc_q + 1'b1;
				end
				tstc_pkg::BS_OUT: begin
					if (!res_v_q || out_ready) begin
						res_v_q            <= 1'b1;
						res_q.num_variants <= 7'(dist_q);
						res_q.has_conflict <= (dist_q > CW'(1));
						res_q.overflow     <= ovf_q;
						gcnt_q             <= '0;
						icnt_q             <= '0;
						nc_q               <= '0;
						ovf_q              <= 1'b0;
						have_prev_q        <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
